FILE: rtl/core/ttfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttfp_pkg;
  localparam int MaxCoresDefault = 1024;
  localparam int PrefixBytes  = 24;
  localparam int BlkHdrBytes  = 8;
  localparam int RecordBytes  = 28;
  localparam int TrailerBytes = 12;

  typedef enum logic [1:0] {
    KIND_BURST = 2'd0, KIND_FRAME = 2'd1, KIND_STREAM = 2'd2, KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_TILE_SEQ = 4'd0, ERR_BLK_COUNT = 4'd1, ERR_MAC = 4'd2, ERR_SHORT = 4'd3,
    ERR_CORE_RANGE = 4'd4, ERR_CORE_ORDER = 4'd5, ERR_BURST_CNT = 4'd6,
    ERR_TICK_NEG = 4'd7, ERR_TICK_ORDER = 4'd8, ERR_EMPTY_RUN = 4'd9,
    ERR_LEN = 4'd10, ERR_TAIL = 4'd11, ERR_MAGIC = 4'd12, ERR_TOTAL = 4'd13,
    ERR_TRUNC = 4'd14
  } err_t;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001, PH_BLOCK = 4'b0010, PH_RECORD = 4'b0100, PH_TRAILER = 4'b1000
  } phase_t;

  localparam int CfgTileCount = 0;
  localparam int CfgCoreCount = 1;
  localparam int CfgMagic     = 2;

  // tdata width of one result: 2+4+31+10+63+32*5+63+63 = 396 bits -> 400
  localparam int ResBits  = 396;
  localparam int OutBytes = 400;

  typedef struct packed {
    logic [62:0] tail;
    logic [62:0] mac;
    logic [31:0] run_length;
    logic [31:0] run_first;
    logic [31:0] in_channel;
    logic [31:0] kernel_col;
    logic [31:0] kernel_row;
    logic [62:0] burst_tick;
    logic [9:0]  core;
    logic [30:0] tile;
    err_t        err;
    kind_t       kind;
  } result_t;

  // one finished structure: phase, stream end flag and four 64-bit fields
  typedef struct packed {
    logic        valid;
    phase_t      phase;
    logic        stream_end;
    logic [63:0] f0;
    logic [63:0] f1;
    logic [63:0] f2;
    logic [63:0] f3;
  } frag_t;
endpackage
`default_nettype wire

FILE: rtl/core/ttfp_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ttfp_out_fifo import ttfp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_a,
  input  wire result_t data_a,
  input  wire logic    push_b,
  input  wire result_t data_b,
  output logic         almost_full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);
  // four entries; two may enter per cycle
  result_t     mem_r [4];
  logic [1:0]  rd_r, wr_r;
  logic [2:0]  cnt_r;
  logic        pop;
  logic [1:0]  npush;

  assign pop         = out_valid && out_ready;
  assign out_valid   = cnt_r != 3'd0;
  assign out_data    = mem_r[rd_r];
  assign npush       = {1'b0, push_a} + {1'b0, push_b};
  // stall input when fewer than two entries are free
  assign almost_full = cnt_r > 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (pop) rd_r <= rd_r + 2'd1;
      wr_r  <= wr_r + npush;
      cnt_r <= cnt_r + {1'b0, npush} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) mem_r[wr_r] <= data_a;
    if (push_b) mem_r[push_a ? wr_r + 2'd1 : wr_r] <= data_b;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push_b |-> push_a)
    else $error("second result without first");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 && npush == 2'd0) |=> !out_valid)
    else $error("spurious result");
endmodule
`default_nettype wire

FILE: rtl/core/ttfp_check.sv
`timescale 1ns / 1ps
`default_nettype none
module ttfp_check import ttfp_pkg::*; #(
  parameter int MAX_CORES = MaxCoresDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_end,
  input  wire logic        in_fire,
  input  wire logic [30:0] tile_count,
  input  wire logic [10:0] core_count,
  input  wire logic [31:0] trailer_magic,
  output logic             running,
  output logic             push_a,
  output result_t          res_a,
  output logic             push_b,
  output result_t          res_b
);
  phase_t      phase_r, phase_nxt;
  logic [4:0]  off_r;
  logic [63:0] fld_r [4];
  logic [30:0] tiles_r, tiles_nxt;
  logic [10:0] blocks_r, blocks_nxt;
  logic [30:0] bursts_r, bursts_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic signed [11:0] lcore_r, lcore_nxt;
  logic signed [63:0] ltick_r, ltick_nxt;
  logic [62:0] big_r, big_nxt;
  logic [62:0] mac_r, mac_nxt;
  logic [63:0] total_r, total_nxt;
  logic        run_r, run_nxt;

  phase_t      ph;
  logic [63:0] w [4];
  logic [4:0]  len;
  logic        done;
  logic [31:0] effc;
  logic        fail;
  err_t        fcode;
  logic        emit_burst, emit_frame, emit_stream;
  logic [62:0] tail;
  logic signed [31:0] rs, re, bcore, bn;
  logic [31:0] nblk;
  logic [63:0] tick;
  logic [4:0]  off_nxt;

  assign effc    = (32'(core_count) > 32'(MAX_CORES)) ? 32'(MAX_CORES) : 32'(core_count);
  assign running = run_r;

  always_comb begin
    ph = phase_r;
    if (off_r == 5'd0 && phase_r == PH_PREFIX && tiles_r >= tile_count) ph = PH_TRAILER;
    for (int i = 0; i < 4; i++) w[i] = (off_r == 5'd0) ? 64'd0 : fld_r[i];
    w[off_r[4:3]][off_r[2:0]*8 +: 8] = data_byte;
    unique case (ph)
      PH_PREFIX:  len = 5'(PrefixBytes);
      PH_BLOCK:   len = 5'(BlkHdrBytes);
      PH_RECORD:  len = 5'(RecordBytes);
      PH_TRAILER: len = 5'(TrailerBytes);
      default:    len = 5'(TrailerBytes);
    endcase
    done    = (off_r + 5'd1) >= len;
    off_nxt = done ? 5'd0 : off_r + 5'd1;

    phase_nxt = ph; tiles_nxt = tiles_r; blocks_nxt = blocks_r; bursts_nxt = bursts_r;
    pay_nxt = pay_r; lcore_nxt = lcore_r; ltick_nxt = ltick_r; big_nxt = big_r;
    mac_nxt = mac_r; total_nxt = total_r; run_nxt = run_r;
    fail = 1'b0; fcode = ERR_TRUNC;
    emit_burst = 1'b0; emit_frame = 1'b0; emit_stream = 1'b0;
    tail = '0;
    nblk = w[0][63:32]; tick = w[0];
    bcore = w[0][31:0]; bn = w[0][63:32];
    rs = w[2][63:32]; re = w[3][31:0];

    if (done) begin
      unique case (ph)
        PH_PREFIX: begin
          if (w[0][31:0] != {1'b0, tiles_r}) begin fail = 1'b1; fcode = ERR_TILE_SEQ; end
          else if (nblk[31] || nblk > effc) begin fail = 1'b1; fcode = ERR_BLK_COUNT; end
          else if (w[1][63] || w[1] == 64'd0) begin fail = 1'b1; fcode = ERR_MAC; end
          else begin
            mac_nxt = w[1][62:0]; big_nxt = '0; lcore_nxt = -12'sd1;
            blocks_nxt = nblk[10:0];
            if (nblk == 32'd0) begin
              if (w[2] != 64'd0) begin fail = 1'b1; fcode = ERR_LEN; end
              else begin
                emit_frame = 1'b1; tail = w[1][62:0];
                tiles_nxt = tiles_r + 31'd1; phase_nxt = PH_PREFIX;
              end
            end else if (w[2] < 64'(BlkHdrBytes)) begin fail = 1'b1; fcode = ERR_SHORT; end
            else begin pay_nxt = w[2] - 64'(BlkHdrBytes); phase_nxt = PH_BLOCK; end
          end
        end
        PH_BLOCK: begin
          if (bcore < 0 || 33'(bcore) >= 33'(effc)) begin fail = 1'b1; fcode = ERR_CORE_RANGE; end
          else if (12'(bcore) <= lcore_r) begin fail = 1'b1; fcode = ERR_CORE_ORDER; end
          else if (bn < 1) begin fail = 1'b1; fcode = ERR_BURST_CNT; end
          else if (pay_r < 64'(RecordBytes)) begin fail = 1'b1; fcode = ERR_SHORT; end
          else begin
            lcore_nxt = 12'(bcore); bursts_nxt = bn[30:0]; ltick_nxt = -64'sd1;
            pay_nxt = pay_r - 64'(RecordBytes); phase_nxt = PH_RECORD;
          end
        end
        PH_RECORD: begin
          if (tick[63]) begin fail = 1'b1; fcode = ERR_TICK_NEG; end
          else if ($signed(tick) <= ltick_r) begin fail = 1'b1; fcode = ERR_TICK_ORDER; end
          else if (re <= rs) begin fail = 1'b1; fcode = ERR_EMPTY_RUN; end
          else begin
            emit_burst = 1'b1;
            ltick_nxt = $signed(tick);
            if (tick[62:0] > big_r) big_nxt = tick[62:0];
            total_nxt = total_r + 64'd1;
            bursts_nxt = bursts_r - 31'd1;
            if (bursts_r != 31'd1) begin
              if (pay_r < 64'(RecordBytes)) begin fail = 1'b1; fcode = ERR_SHORT; end
              else begin pay_nxt = pay_r - 64'(RecordBytes); phase_nxt = PH_RECORD; end
            end else begin
              blocks_nxt = blocks_r - 11'd1;
              if (blocks_r != 11'd1) begin
                if (pay_r < 64'(BlkHdrBytes)) begin fail = 1'b1; fcode = ERR_SHORT; end
                else begin pay_nxt = pay_r - 64'(BlkHdrBytes); phase_nxt = PH_BLOCK; end
              end else if (pay_r != 64'd0) begin fail = 1'b1; fcode = ERR_LEN; end
              else if (mac_r <= big_nxt) begin fail = 1'b1; fcode = ERR_TAIL; end
              else begin
                emit_frame = 1'b1; tail = mac_r - big_nxt;
                tiles_nxt = tiles_r + 31'd1; phase_nxt = PH_PREFIX;
              end
            end
          end
        end
        PH_TRAILER: begin
          if (w[0][31:0] != trailer_magic) begin fail = 1'b1; fcode = ERR_MAGIC; end
          else if ({w[1][31:0], w[0][63:32]} != total_r) begin fail = 1'b1; fcode = ERR_TOTAL; end
          else emit_stream = 1'b1;
        end
        default: ;
      endcase
    end
    if (!fail && !emit_stream && stream_end) begin fail = 1'b1; fcode = ERR_TRUNC; end
    if (fail || emit_stream) run_nxt = 1'b0;
  end

  // first result of a step: burst or frame/stream/error; second: frame after burst, or error
  always_comb begin
    res_a = '0; res_b = '0;
    res_a.tile = tiles_r; res_b.tile = tiles_r;
    if (emit_burst) begin
      res_a.kind = KIND_BURST; res_a.core = lcore_r[9:0]; res_a.burst_tick = tick[62:0];
      res_a.kernel_row = w[1][31:0]; res_a.kernel_col = w[1][63:32];
      res_a.in_channel = w[2][31:0]; res_a.run_first = w[2][63:32];
      res_a.run_length = 32'(re - rs);
      if (emit_frame) begin
        res_b.kind = KIND_FRAME; res_b.mac = mac_r; res_b.tail = tail;
      end else begin
        res_b.kind = KIND_ERROR; res_b.err = fcode;
      end
      push_b = in_fire && run_r && (emit_frame || fail);
    end else begin
      push_b = 1'b0;
      if (emit_frame) begin
        res_a.kind = KIND_FRAME; res_a.mac = (ph == PH_PREFIX) ? w[1][62:0] : mac_r;
        res_a.tail = tail;
        // an error after a frame done belongs to the next tile
        res_b.kind = KIND_ERROR; res_b.err = fcode; res_b.tile = tiles_r + 31'd1;
        push_b = in_fire && run_r && fail;
      end else if (emit_stream) begin
        res_a.kind = KIND_STREAM;
      end else begin
        res_a.kind = KIND_ERROR; res_a.err = fcode;
      end
    end
    push_a = in_fire && run_r && (emit_burst || emit_frame || emit_stream || fail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX; off_r <= '0; tiles_r <= '0; blocks_r <= '0; bursts_r <= '0;
      pay_r <= '0; lcore_r <= -12'sd1; ltick_r <= -64'sd1; big_r <= '0; mac_r <= '0;
      total_r <= '0; run_r <= 1'b1;
    end else if (in_fire && run_r) begin
      phase_r <= phase_nxt; off_r <= off_nxt; tiles_r <= tiles_nxt;
      blocks_r <= blocks_nxt; bursts_r <= bursts_nxt; pay_r <= pay_nxt; lcore_r <= lcore_nxt;
      ltick_r <= ltick_nxt; big_r <= big_nxt; mac_r <= mac_nxt; total_r <= total_nxt;
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && run_r) for (int i = 0; i < 4; i++) fld_r[i] <= w[i];
  end

  assert property (@(posedge clk) disable iff (!rst_n) push_b |-> push_a)
    else $error("second result without first");
  assert property (@(posedge clk) disable iff (!rst_n) !run_r |=> !run_r)
    else $error("halt not sticky");
  assert property (@(posedge clk) disable iff (!rst_n) off_r < 5'(RecordBytes))
    else $error("byte offset out of range");
endmodule
`default_nettype wire

FILE: rtl/core/tile_trace_frame_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Tile trace frame parser: one stream byte per beat, decoded in one pass.
// Results enter the result queue on the beat that completes them and are offered
// from its head; a second result from the same beat follows once the first has left.
// Throughput: one byte per cycle; input stalls only while fewer than two of the
// four result queue entries are free, i.e. under output back-pressure.
// Reset: rst_n synchronous, active low; parser to frame prefix, queue empty.
module tile_trace_frame_parser_top import ttfp_pkg::*; #(
  parameter int MAX_CORES = MaxCoresDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tlast,   // stream_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // kind,error_code,tile,core,tick,krow,kcol,ich,run_first,run_length,mac,tail
  output logic [OutBytes-1:0] out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  logic [30:0] tile_count_r;
  logic [10:0] core_count_r;
  logic [31:0] magic_r;
  logic        fire, running, push_a, push_b, afull;
  result_t     res_a, res_b, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_count_r <= '0; core_count_r <= 11'd1; magic_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'(CfgTileCount): tile_count_r <= cfg_data[30:0];
        2'(CfgCoreCount): core_count_r <= cfg_data[10:0];
        2'(CfgMagic):     magic_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // halted parser swallows bytes
  assign in_tready = !afull || !running;
  assign fire      = in_tvalid && in_tready;

  ttfp_check #(.MAX_CORES(MAX_CORES)) u_check (
    .clk, .rst_n, .data_byte(in_tdata), .stream_end(in_tlast), .in_fire(fire),
    .tile_count(tile_count_r), .core_count(core_count_r), .trailer_magic(magic_r),
    .running, .push_a, .res_a, .push_b, .res_b
  );

  ttfp_out_fifo u_fifo (
    .clk, .rst_n, .push_a, .data_a(res_a), .push_b, .data_b(res_b),
    .almost_full(afull), .out_valid(out_tvalid), .out_ready(out_tready), .out_data(head)
  );

  assign out_tdata = {4'd0, head};
endmodule
`default_nettype wire
